FILE: rtl/cfc_pkg.sv
// ----------------------------------------------------------------------------
// cfc_pkg: shared constants and types for the causal FIR convolution core
// Field widths, word layouts, action codes and the cell control bundle.
// ----------------------------------------------------------------------------
package cfc_pkg;

    localparam int DEF_MAX_TAPS = 16;

    localparam int TAP_COUNT_W  = 5;
    localparam int COEF_IDX_W   = 4;
    localparam int SAMPLE_W     = 16;
    localparam int PROD_W       = 2 * SAMPLE_W;
    localparam int OUT_W        = 38;

    localparam int S_TDATA_W    = 40;
    localparam int S_TUSER_W    = 2;
    localparam int M_TDATA_W    = 40;

    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = TAP_COUNT_W'(16);

    localparam logic ACTION_COEF   = 1'b0;
    localparam logic ACTION_SAMPLE = 1'b1;

    localparam longint OUT_MAX = 64'sd137438953471;
    localparam longint OUT_MIN = -64'sd137438953472;

    typedef struct packed {
        logic                       shift_en;
        logic signed [SAMPLE_W-1:0] coef_value;
    } cell_ctrl_t;

endpackage

FILE: rtl/cfc_cell.sv
// ----------------------------------------------------------------------------
// cfc_cell: one tap of the FIR chain
// Holds one delayed sample and one coefficient, forms their product and, when
// the tap is active, adds it to the partial sum handed in by the previous cell.
// ----------------------------------------------------------------------------
module cfc_cell #(
    parameter int ACC_W = 36
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cfc_pkg::cell_ctrl_t                ctrl,
    input  logic                               coef_we,
    input  logic                               tap_active,
    input  logic signed [cfc_pkg::SAMPLE_W-1:0] sample_in,
    output logic signed [cfc_pkg::SAMPLE_W-1:0] sample_out,
    input  logic signed [ACC_W-1:0]            sum_in,
    output logic signed [ACC_W-1:0]            sum_out
);
    import cfc_pkg::*;

    logic signed [SAMPLE_W-1:0] hist_reg;
    logic signed [SAMPLE_W-1:0] coef_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    sum_reg;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
            coef_reg <= '0;
        end
        else
        begin
            if (ctrl.shift_en)
            begin
                hist_reg <= sample_in;
            end
            if (coef_we)
            begin
                coef_reg <= ctrl.coef_value;
            end
        end
    end

    always_comb
    begin
        prod_ext = ACC_W'(prod_reg);
        sum_next = tap_active ? (sum_in + prod_ext) : sum_in;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= hist_reg * coef_reg;
        sum_reg  <= sum_next;
    end

    assign sample_out = hist_reg;
    assign sum_out    = sum_reg;

endmodule

FILE: rtl/causal_fir_convolution_core.sv
// ----------------------------------------------------------------------------
// causal_fir_convolution_core: direct-form FIR filter built from a tap chain
// A sample word gives one result word; a coefficient word writes its tap's
// coefficient register and gives no result. Only one sample word is in
// flight: another is accepted once the sum has passed the product register,
// rippled through the chain one cell per cycle and been handed to the output
// register; coefficient words go one per cycle while no sample is in flight.
// Reset clears history, coefficients and tap_count (to 16).
// ----------------------------------------------------------------------------
module causal_fir_convolution_core #(
    parameter int MAX_TAPS = cfc_pkg::DEF_MAX_TAPS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration: tap_count
    input  logic                                cfg_we,
    input  logic [cfc_pkg::TAP_COUNT_W-1:0]     cfg_wdata,
    // Input words
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: coeff_index[3:0], coeff_value[19:4], sample_value[35:20], zero
    input  logic [cfc_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // tuser: action[0], first_of_sequence[1]
    input  logic [cfc_pkg::S_TUSER_W-1:0]       s_axis_tuser,
    // Result words
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: filtered_value[37:0], zero
    output logic [cfc_pkg::M_TDATA_W-1:0]       m_axis_tdata
);
    import cfc_pkg::*;

    // The accumulator holds MAX_TAPS full-scale products without overflow.
    localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);
    localparam int SAT_W = (ACC_W > OUT_W) ? ACC_W : OUT_W;
    localparam int CNT_W = $clog2(MAX_TAPS + 2);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(MAX_TAPS + 1);
    localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(OUT_MAX);
    localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(OUT_MIN);

    // Unpacked input fields.
    logic                       in_action;
    logic                       in_first;
    logic [COEF_IDX_W-1:0]      in_coeff_index;
    logic signed [SAMPLE_W-1:0] in_coeff_value;
    logic signed [SAMPLE_W-1:0] in_sample_value;

    assign in_action       = s_axis_tuser[0];
    assign in_first        = s_axis_tuser[1];
    assign in_coeff_index  = s_axis_tdata[3:0];
    assign in_coeff_value  = s_axis_tdata[19:4];
    assign in_sample_value = s_axis_tdata[35:20];

    logic [TAP_COUNT_W-1:0] tap_count_reg;
    logic                   busy_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg;

    logic       in_fire;
    logic       sample_fire;
    logic       coef_fire;
    logic       result_ready;
    logic       out_load;
    cell_ctrl_t cell_ctrl;

    // The chain is untouched while a sum ripples through it, so only one
    // sample word is in flight. A new word may still be taken while the last
    // result waits at the output register.
    assign s_axis_tready = !busy_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign sample_fire   = in_fire && (in_action == ACTION_SAMPLE);
    assign coef_fire     = in_fire && (in_action == ACTION_COEF);

    assign result_ready  = busy_reg && (cnt_reg == '0);
    assign out_load      = result_ready && (!out_valid_reg || m_axis_tready);

    assign cell_ctrl.shift_en   = sample_fire;
    assign cell_ctrl.coef_value = in_coeff_value;

    // Tap chain: history shifts one cell per sample word, and the partial
    // sum moves one cell per cycle toward the tail.
    logic signed [SAMPLE_W-1:0] hist_w  [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] chain_w [MAX_TAPS];
    logic signed [ACC_W-1:0]    sum_w   [MAX_TAPS];

    genvar k;
    generate
        for (k = 0; k < MAX_TAPS; k++)
        begin : g_tap
            logic                    cell_coef_we;
            logic                    cell_active;
            logic signed [ACC_W-1:0] cell_sum_in;

            // Indexes at or above the chain length never match and are dropped.
            assign cell_coef_we = coef_fire && (int'(in_coeff_index) == k);
            assign cell_active  = int'(tap_count_reg) > k;

            if (k == 0)
            begin : g_head
                assign chain_w[k]  = in_sample_value;
                assign cell_sum_in = '0;
            end
            else
            begin : g_body
                // A first-of-sequence sample empties the rest of the line.
                assign chain_w[k]  = in_first ? '0 : hist_w[k-1];
                assign cell_sum_in = sum_w[k-1];
            end

            cfc_cell #(
                .ACC_W (ACC_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .coef_we    (cell_coef_we),
                .tap_active (cell_active),
                .sample_in  (chain_w[k]),
                .sample_out (hist_w[k]),
                .sum_in     (cell_sum_in),
                .sum_out    (sum_w[k])
            );
        end
    endgenerate

    // Clamp the tail sum to the 38-bit result range.
    logic signed [SAT_W-1:0] tail_ext;
    logic signed [SAT_W-1:0] tail_sat;

    always_comb
    begin
        tail_ext = SAT_W'(sum_w[MAX_TAPS-1]);
        if (tail_ext > SAT_MAX)
        begin
            tail_sat = SAT_MAX;
        end
        else if (tail_ext < SAT_MIN)
        begin
            tail_sat = SAT_MIN;
        end
        else
        begin
            tail_sat = tail_ext;
        end
    end

    // Control: count the ripple, then hand the sum to the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RESET;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tap_count_reg <= cfg_wdata;
            end

            if (sample_fire)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_LOAD;
            end
            else if (out_load)
            begin
                busy_reg <= 1'b0;
            end
            else if (busy_reg && (cnt_reg != '0))
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= tail_sat[OUT_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W-OUT_W){1'b0}}, out_data_reg};

    // A sample word always starts a full ripple count.
    a_sample_starts_ripple: assert property (
        @(posedge clk) disable iff (!rst_n)
        sample_fire |=> (busy_reg && (cnt_reg == CNT_LOAD))
    ) else $error("sample word did not start the ripple count");

    // The output register is loaded only once the ripple has finished.
    a_load_after_ripple: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_load |-> (busy_reg && (cnt_reg == '0) && !sample_fire)
    ) else $error("result loaded before the chain settled");

    // A new result never overwrites one that has not been taken.
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready && result_ready) |=> busy_reg
    ) else $error("pending result was dropped");

endmodule
